// ===== rtl/smac_pkg.sv =====
// ----------------------------------------------------------------------------
// smac_pkg: shared types and codes for the substring match block
// Holds the configuration view that the register file hands to the scanner,
// the register indexes and the verdict codes.
// ----------------------------------------------------------------------------
package smac_pkg;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_PAT_LEN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAT_BYTES = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_0   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_1   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_2   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_3   = 3'd5;

    // Verdict codes given on the last byte of a word.
    localparam logic [1:0] VERDICT_NO_MATCH = 2'd0;
    localparam logic [1:0] VERDICT_MATCH    = 2'd1;
    localparam logic [1:0] VERDICT_FOREIGN  = 2'd2;

    // Register contents as seen by the scanner.
    typedef struct packed {
        logic [3:0]   pat_len;
        logic [63:0]  pat_bytes;
        logic [255:0] alphabet;
    } t_cfg_view;

endpackage

// ===== rtl/substring_match_with_alphabet_check.sv =====
// ----------------------------------------------------------------------------
// substring_match_with_alphabet_check: per-word substring and alphabet check
// Streams a word one byte per transfer and gives one verdict on its last byte:
// foreign byte, pattern found, or pattern not found.
//
//   Channel    Direction  Signals                         Content
//   s_axis     in         tvalid tready tdata tlast       symbol, word_end
//   m_axis     out        tvalid tready tdata             verdict
//   cfg        in         i_cfg_we i_cfg_addr i_cfg_data  register writes
//
// One byte per cycle while no held verdict stalls a last byte; each byte waits
// in the input register, is scanned from there, and a last byte's verdict goes
// into the verdict register. A verdict is valid on m_axis from the edge at which
// its last byte leaves the input register.
// Reset is synchronous and active low; it clears the word state and valid bits and resets the registers.
// A held verdict stalls the next last byte in the input register and the bytes
// behind it; other bytes keep flowing.
// ----------------------------------------------------------------------------
module substring_match_with_alphabet_check #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Byte stream in.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] symbol
    input  logic                             s_axis_tlast,  // word_end
    // Verdict stream out.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [1:0] verdict, [7:2] zero
    // Configuration writes.
    input  logic                             i_cfg_we,
    input  logic [smac_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [smac_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import smac_pkg::*;

    t_cfg_view  w_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_sym;
    logic       r_in_last;
    logic       r_out_valid;
    logic [1:0] r_out_verdict;
    logic       w_out_free;
    logic       w_adv;
    logic [1:0] w_verdict;

    smac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    smac_scan #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_symbol  (r_in_sym),
        .i_last    (r_in_last),
        .i_cfg     (w_cfg),
        .o_verdict (w_verdict)
    );

    // Flow control: only a last byte needs room in the verdict register.
    assign w_out_free    = ~r_out_valid | m_axis_tready;
    assign w_adv         = r_in_valid & (~r_in_last | w_out_free);
    assign s_axis_tready = ~r_in_valid | w_adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sym  <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Verdict register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_verdict <= w_verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out_verdict};

    // A verdict only appears after a last byte was scanned.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv && r_in_last))
        else $error("verdict raised without a scanned last byte");

    // A byte waiting in the input register is kept until it is scanned.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_sym) && $stable(r_in_last))
        else $error("waiting input byte was overwritten");

    // A waiting verdict is never replaced by the next one.
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !(w_adv && r_in_last))
        else $error("verdict overwritten before transfer");

    // Only defined verdict codes leave the block.
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_verdict == VERDICT_NO_MATCH ||
                         r_out_verdict == VERDICT_MATCH ||
                         r_out_verdict == VERDICT_FOREIGN))
        else $error("undefined verdict code");

endmodule

// ===== rtl/smac_cfg.sv =====
// ----------------------------------------------------------------------------
// smac_cfg: configuration register file
// Takes indexed writes and presents pattern length, pattern bytes and the
// 256-bit alphabet set as one structure. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module smac_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [smac_pkg::CFG_ADDR_W-1:0]  i_addr,
    input  logic [smac_pkg::CFG_DATA_W-1:0]  i_data,
    output smac_pkg::t_cfg_view              o_cfg
);
    import smac_pkg::*;

    logic [3:0]   r_pat_len;
    logic [63:0]  r_pat_bytes;
    logic [255:0] r_alphabet;

    // Register writes, decoded by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= 4'd1;
            r_pat_bytes <= '0;
            r_alphabet  <= '0;
        end else if (i_we) begin
            unique case (i_addr)
                REG_PAT_LEN:   r_pat_len           <= i_data[3:0];
                REG_PAT_BYTES: r_pat_bytes         <= i_data;
                REG_ALPHA_0:   r_alphabet[63:0]    <= i_data;
                REG_ALPHA_1:   r_alphabet[127:64]  <= i_data;
                REG_ALPHA_2:   r_alphabet[191:128] <= i_data;
                REG_ALPHA_3:   r_alphabet[255:192] <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.pat_len   = r_pat_len;
    assign o_cfg.pat_bytes = r_pat_bytes;
    assign o_cfg.alphabet  = r_alphabet;

endmodule

// ===== rtl/smac_scan.sv =====
// ----------------------------------------------------------------------------
// smac_scan: window, pattern compare and sticky word flags
// Shifts each byte into a window of recent bytes, compares the newest bytes
// against the pattern in parallel, checks alphabet membership and forms the
// verdict. The word state clears after the last byte of a word.
// ----------------------------------------------------------------------------
module smac_scan #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_symbol,
    input  logic                i_last,
    input  smac_pkg::t_cfg_view i_cfg,
    output logic [1:0]          o_verdict
);
    import smac_pkg::*;

    localparam int         FW      = $clog2(MAX_PATTERN + 1);
    localparam logic [3:0] MAX_LEN = 4'(MAX_PATTERN);

    logic [7:0]    r_win [MAX_PATTERN];
    logic [7:0]    n_win [MAX_PATTERN];
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          r_match;
    logic          n_match;
    logic          r_foreign;
    logic          n_foreign;
    logic [3:0]    w_len;
    logic          w_hit;

    // Effective pattern length: zero counts as one, long values saturate.
    always_comb begin
        if (i_cfg.pat_len == 4'd0) begin
            w_len = 4'd1;
        end else if (i_cfg.pat_len > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = i_cfg.pat_len;
        end
    end

    // Window after this byte and the saturating fill count.
    always_comb begin
        n_win[0] = i_symbol;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_fill = (r_fill == FW'(MAX_PATTERN)) ? r_fill : r_fill + 1'b1;
    end

    // Parallel compare: window entry k holds the pattern byte len-1-k.
    always_comb begin
        logic [2:0] pos;
        pos   = '0;
        w_hit = (4'(n_fill) >= w_len);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pos = 3'(w_len - 4'd1 - 4'(k));
            if ((4'(k) < w_len) && (n_win[k] != i_cfg.pat_bytes[{pos, 3'b000} +: 8])) begin
                w_hit = 1'b0;
            end
        end
    end

    // Sticky flags including this byte.
    assign n_match   = r_match | w_hit;
    assign n_foreign = r_foreign | ~i_cfg.alphabet[i_symbol];

    // Verdict for a word that ends with this byte.
    always_comb begin
        if (n_foreign) begin
            o_verdict = VERDICT_FOREIGN;
        end else if (n_match) begin
            o_verdict = VERDICT_MATCH;
        end else begin
            o_verdict = VERDICT_NO_MATCH;
        end
    end

    // Word state: cleared after the last byte of a word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_match   <= 1'b0;
            r_foreign <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_fill    <= '0;
                r_match   <= 1'b0;
                r_foreign <= 1'b0;
            end else begin
                r_fill    <= n_fill;
                r_match   <= n_match;
                r_foreign <= n_foreign;
            end
        end
    end

    // Window bytes. Entries beyond the fill count are never compared, so
    // they need no clearing between words.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_win <= n_win;
        end
    end

    // The fill count never passes the window depth.
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        4'(r_fill) <= MAX_LEN)
        else $error("window fill count above window depth");

    // A word end leaves the word state cleared.
    a_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> (r_fill == '0) && !r_match && !r_foreign)
        else $error("word state not cleared after last byte");

endmodule

// ===== bench/smac_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// smac_verdict_checker: verdict predictor and scoreboard for the substring block
// Watches the configuration port and both stream channels, keeps its own copy
// of the registers and of the per-word scan state, and queues one expected
// verdict for every last byte. Each verdict transfer is compared against the
// oldest queued verdict. Mismatches and unexpected verdicts are counted.
// ----------------------------------------------------------------------------
module smac_verdict_checker #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Byte stream into the block.
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] symbol
    input  logic                             s_axis_tlast,  // word_end
    // Verdict stream out of the block.
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [7:0]                       m_axis_tdata,  // [1:0] verdict, [7:2] zero
    // Configuration writes.
    input  logic                             i_cfg_we,
    input  logic [smac_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [smac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Status toward the testbench top.
    output int                               o_fail_count,
    output int                               o_pending
);

    import smac_pkg::*;

    // Shadow copy of the registers.
    logic [3:0]   pat_len_q;
    logic [63:0]  pat_bytes_q;
    logic [255:0] alphabet_q;

    // Per-word scan state; entry 0 of the window holds the newest byte.
    logic [7:0]   window_q [MAX_PATTERN];
    int unsigned  fill_q;
    logic         match_q;
    logic         foreign_q;

    // Verdicts owed by the block, oldest first.
    logic [1:0]   verdicts_due [$];

    // Track register writes, predict a verdict per word and check each transfer.
    always @(posedge i_clk) begin : word_scan
        logic [7:0]  sym;
        logic [1:0]  want_v;
        logic [1:0]  got_v;
        int unsigned len;
        logic        hit;

        if (!i_rst_n) begin
            pat_len_q    = 4'd1;
            pat_bytes_q  = '0;
            alphabet_q   = '0;
            window_q     = '{default: '0};
            fill_q       = 0;
            match_q      = 1'b0;
            foreign_q    = 1'b0;
            o_fail_count = 0;
            verdicts_due.delete();
        end else begin
            // Register writes; indexes above the last register are dropped.
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_PAT_LEN:   pat_len_q = i_cfg_data[3:0];
                    REG_PAT_BYTES: pat_bytes_q = i_cfg_data;
                    REG_ALPHA_0:   alphabet_q[63:0] = i_cfg_data;
                    REG_ALPHA_1:   alphabet_q[127:64] = i_cfg_data;
                    REG_ALPHA_2:   alphabet_q[191:128] = i_cfg_data;
                    REG_ALPHA_3:   alphabet_q[255:192] = i_cfg_data;
                    default: ;
                endcase
            end

            // Compare the verdict transfer first so a verdict queued on this
            // edge can never be taken by a transfer on the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got_v = m_axis_tdata[1:0];
                if (verdicts_due.size() == 0) begin
                    $display("%0t: verdict with none expected, expected none, actual %0d",
                             $time, got_v);
                    o_fail_count++;
                end else begin
                    want_v = verdicts_due.pop_front();
                    if (got_v !== want_v) begin
                        $display("%0t: verdict mismatch, expected %0d, actual %0d",
                                 $time, want_v, got_v);
                        o_fail_count++;
                    end
                end
            end

            // Scan one accepted byte.
            if (s_axis_tvalid && s_axis_tready) begin
                sym = s_axis_tdata;
                len = pat_len_q;
                if (len == 0)
                    len = 1;
                if (len > MAX_PATTERN)
                    len = MAX_PATTERN;

                if (!alphabet_q[sym])
                    foreign_q = 1'b1;

                for (int k = MAX_PATTERN - 1; k > 0; k--)
                    window_q[k] = window_q[k-1];
                window_q[0] = sym;
                if (fill_q < MAX_PATTERN)
                    fill_q++;

                // The newest byte pairs with the last pattern byte.
                if (fill_q >= len) begin
                    hit = 1'b1;
                    for (int k = 0; k < len; k++) begin
                        if (window_q[k] != pat_bytes_q[8*(len-1-k) +: 8])
                            hit = 1'b0;
                    end
                    if (hit)
                        match_q = 1'b1;
                end

                if (s_axis_tlast) begin
                    if (foreign_q)
                        verdicts_due = {verdicts_due, VERDICT_FOREIGN};
                    else if (match_q)
                        verdicts_due = {verdicts_due, VERDICT_MATCH};
                    else
                        verdicts_due = {verdicts_due, VERDICT_NO_MATCH};
                    window_q  = '{default: '0};
                    fill_q    = 0;
                    match_q   = 1'b0;
                    foreign_q = 1'b0;
                end
            end
        end
        o_pending = verdicts_due.size();
    end

endmodule

// ===== bench/tb_substring_match_with_alphabet_check.sv =====
// ----------------------------------------------------------------------------
// tb_substring_match_with_alphabet_check: stimulus and verdict for the block
// Runs a short directed set of words covering the register extremes, then
// random phases of words built from pattern bytes, random bytes and bytes left
// out of the alphabet. Both stream sides idle in random bursts, and one phase
// holds off the verdict side long enough to stall the byte stream. The
// checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_substring_match_with_alphabet_check;

    import smac_pkg::*;

    typedef logic [7:0] t_byte_q [$];

    localparam int MAX_PATTERN    = 8;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 300;
    localparam int NUM_PHASES     = 6;
    localparam int BYTES_PER_PHASE = 165;

    // Register indexes past the last register; writes there are dropped.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] symbol
    logic                   s_axis_tlast;   // word_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata;   // [1:0] verdict, [7:2] zero
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int                     fail_count;
    int                     verdicts_pending;
    int                     cycle_count = 0;

    // Stimulus shaping; the idle and hold flags are shared with the verdict-side process.
    bit                     idle_on;
    bit                     hold_req;
    bit                     hold_done;
    int unsigned            cur_len;
    logic [63:0]            cur_pat;
    logic [7:0]             cur_hole [4];

    substring_match_with_alphabet_check #(
        .MAX_PATTERN (MAX_PATTERN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    smac_verdict_checker #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (verdicts_pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Verdict side: random stalls, one long hold-off on request, none at the end.
    initial begin : verdict_side
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // Offer one byte, with an optional idle burst first, and wait for its transfer.
    task automatic send_byte(input logic [7:0] sym, input logic last);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic send_word(input t_byte_q word);
        for (int k = 0; k < word.size(); k++)
            send_byte(word[k], k == word.size() - 1);
    endtask

    // Wait until every owed verdict has been taken, then let the block settle.
    task automatic drain_verdicts();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (verdicts_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Write every register; random upper bits ride along with the length field.
    task automatic load_config(input logic [3:0] len_field, input logic [63:0] pat,
                               input logic [255:0] alpha);
        put_reg(REG_SPARE_6, {$urandom, $urandom});
        put_reg(REG_PAT_LEN, {$urandom, 28'($urandom), len_field});
        put_reg(REG_PAT_BYTES, pat);
        put_reg(REG_ALPHA_0, alpha[63:0]);
        put_reg(REG_ALPHA_1, alpha[127:64]);
        put_reg(REG_ALPHA_2, alpha[191:128]);
        put_reg(REG_ALPHA_3, alpha[255:192]);
        put_reg(REG_SPARE_7, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        cur_len = (len_field == 0) ? 1 : (len_field > MAX_PATTERN) ? MAX_PATTERN : len_field;
        cur_pat = pat;
    endtask

    // Full alphabet with up to four random byte values knocked out.
    task automatic alphabet_with_holes(output logic [255:0] alpha);
        alpha = '1;
        for (int k = 0; k < 4; k++) begin
            cur_hole[k] = 8'($urandom);
            alpha[cur_hole[k]] = 1'b0;
        end
    endtask

    // A word mixing pattern bytes, random bytes and holes, often with the
    // whole pattern planted somewhere inside. Returns the byte count.
    task automatic send_random_word(output int unsigned nbytes);
        t_byte_q     word;
        int unsigned wlen;
        int unsigned at;
        int unsigned pick;
        bit          plant;

        wlen  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        plant = ($urandom_range(0, 2) == 0);
        if (plant && wlen < cur_len)
            wlen = cur_len + $urandom_range(0, 3);
        for (int k = 0; k < wlen; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                word = {word, cur_pat[8*$urandom_range(0, cur_len - 1) +: 8]};
            else if (pick == 9)
                word = {word, cur_hole[$urandom_range(0, 3)]};
            else
                word = {word, 8'($urandom)};
        end
        if (plant) begin
            at = $urandom_range(0, wlen - cur_len);
            for (int k = 0; k < cur_len; k++)
                word[at + k] = cur_pat[8*k +: 8];
        end
        send_word(word);
        nbytes = wlen;
    endtask

    // Main stimulus.
    initial begin : stimulus
        t_byte_q      word;
        logic [255:0] alpha;
        logic [63:0]  pat;
        logic [3:0]   len_field;
        int unsigned  sent;
        int unsigned  nbytes;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= REG_PAT_LEN;
        i_cfg_data    <= '0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        cur_len   = 1;
        cur_pat   = '0;
        for (int k = 0; k < 4; k++)
            cur_hole[k] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: empty alphabet, so even a matching byte is foreign.
        word = '{8'h00};
        send_word(word);

        // Two-byte pattern "ab": found inside a word, and longer than a word.
        drain_verdicts();
        load_config(4'd2, 64'h0000_0000_0000_6261, '1);
        word = '{8'h78, 8'h61, 8'h62, 8'h79};
        send_word(word);
        word = '{8'h61};
        send_word(word);

        // Length zero acts as length one; the pattern byte is the top value.
        drain_verdicts();
        load_config(4'd0, 64'hA5A5_A5A5_A5A5_A5FF, '1);
        word = '{8'h00, 8'hFF};
        send_word(word);

        // Length above the maximum saturates; full-width match, then a match
        // spoiled by a byte outside the alphabet.
        drain_verdicts();
        pat   = 64'h8877_6655_4433_2211;
        alpha = '1;
        alpha[8'hFF] = 1'b0;
        load_config(4'd15, pat, alpha);
        word.delete();
        for (int k = 0; k < MAX_PATTERN; k++)
            word = {word, pat[8*k +: 8]};
        send_word(word);
        word.push_front(8'hFF);
        send_word(word);

        // Random phases over several register settings.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_verdicts();
            pat = {$urandom, $urandom};
            alphabet_with_holes(alpha);
            case (phase)
                0: len_field = 4'd1;
                1: len_field = 4'd8;
                2: len_field = 4'd0;
                3: len_field = 4'd15;
                4: begin
                    len_field = 4'($urandom_range(1, MAX_PATTERN));
                    alpha = {$urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom};
                end
                default: len_field = 4'($urandom_range(2, 5));
            endcase
            load_config(len_field, pat, alpha);
            if (phase == 2)
                hold_req = 1'b1;
            if (phase == NUM_PHASES - 1)
                idle_on = 1'b0;
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                send_random_word(nbytes);
                sent += nbytes;
            end
        end

        drain_verdicts();
        if (fail_count == 0 && verdicts_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
